// ===== sv/jump_limit_filter_macros.svh =====
// ----------------------------------------------------------------------------
// Jump limit filter assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JUMP_LIMIT_FILTER_MACROS_SVH
`define JUMP_LIMIT_FILTER_MACROS_SVH

// same-cycle implication
`define JLF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JLF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jlf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jump limit filter package
// Register indexes, reset values and the structs passed between modules.
// ----------------------------------------------------------------------------
package jlf_pkg;

  localparam int SampleW = 32;
  localparam int TolW    = 31;
  localparam int QuotaW  = 11;

  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_QUOTA     = 1'b1;

  localparam logic [TolW-1:0]   TOL_RESET   = 31'd327680;
  localparam logic [QuotaW-1:0] QUOTA_RESET = 11'd2;

  typedef struct packed {
    logic [TolW-1:0]   tolerance;
    logic [QuotaW-1:0] quota;     // already clamped to 1..QUOTA_MAX
  } cfg_t;

  typedef struct packed {
    logic sample_go;
    logic restart_go;
  } ctl_t;

  typedef struct packed {
    logic signed [SampleW-1:0] filtered;
    logic                      held;
  } res_t;

endpackage

// ===== sv/jlf_near.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jump limit filter nearness compare
// |a - b| <= tolerance, difference formed at 33 bits so it cannot overflow.
// ----------------------------------------------------------------------------
module jlf_near (
  input  logic signed [jlf_pkg::SampleW-1:0] a,
  input  logic signed [jlf_pkg::SampleW-1:0] b,
  input  logic [jlf_pkg::TolW-1:0]           tolerance,
  output logic                               near
);
  import jlf_pkg::*;

  logic [SampleW:0] diff;
  logic [SampleW:0] mag;

  always_comb begin
    diff = {a[SampleW-1], a} - {b[SampleW-1], b};
    mag  = diff[SampleW] ? (~diff + 1'b1) : diff;
    near = mag <= {2'b00, tolerance};
  end

endmodule

// ===== sv/jlf_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jump limit filter decision core
// Holds the filter state and decides pass or hold for the staged item.
// ----------------------------------------------------------------------------
module jlf_core #(
  parameter int QUOTA_MAX = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  jlf_pkg::cfg_t                      cfg,
  input  jlf_pkg::ctl_t                      ctl,
  input  logic signed [jlf_pkg::SampleW-1:0] sample,
  output jlf_pkg::res_t                      res
);
  import jlf_pkg::*;

  localparam int QW = $clog2(QUOTA_MAX + 1);
  localparam int CW = ((QW > QuotaW) ? QW : QuotaW) + 1;
  localparam logic [QW-1:0] QMAX = QW'(QUOTA_MAX);

  logic [QW-1:0]             seen_count;
  logic [QW-1:0]             seen_count_next;
  logic [QW-1:0]             near_run;
  logic [QW-1:0]             near_run_next;
  logic signed [SampleW-1:0] held_value;
  logic signed [SampleW-1:0] previous_sample;

  logic near_prev;
  logic near_held;
  logic take;
  logic [CW-1:0] q_ext;

  jlf_near u_near_prev (
    .a         (sample),
    .b         (previous_sample),
    .tolerance (cfg.tolerance),
    .near      (near_prev)
  );

  jlf_near u_near_held (
    .a         (sample),
    .b         (held_value),
    .tolerance (cfg.tolerance),
    .near      (near_held)
  );

  always_comb begin
    q_ext = CW'(cfg.quota);
    if ((seen_count != '0) && near_prev) begin
      near_run_next = (near_run < QMAX) ? near_run + 1'b1 : near_run;
    end else begin
      near_run_next = '0;
    end
    seen_count_next = (seen_count < QMAX) ? seen_count + 1'b1 : seen_count;

    take         = 1'b0;
    res.filtered = sample;
    res.held     = 1'b0;
    if (seen_count == '0) begin
      take = 1'b1;
    end else if (CW'(seen_count_next) < q_ext) begin
      if (!near_held) begin
        res.filtered = held_value;
        res.held     = 1'b1;
      end
    end else if (near_held || (CW'(near_run_next) + 1'b1 >= q_ext)) begin
      take = 1'b1;
    end else begin
      res.filtered = held_value;
      res.held     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count      <= '0;
      near_run        <= '0;
      held_value      <= '0;
      previous_sample <= '0;
    end else if (ctl.restart_go) begin
      seen_count <= '0;
    end else if (ctl.sample_go) begin
      seen_count      <= seen_count_next;
      near_run        <= near_run_next;
      previous_sample <= sample;
      if (take) begin
        held_value <= sample;
      end
    end
  end

endmodule

// ===== sv/jump_limit_filter.sv =====
`timescale 1ns / 1ps
`include "jump_limit_filter_macros.svh"
// ----------------------------------------------------------------------------
// Jump limit filter
// Jump limiter on a stream of signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Takes one item per cycle while in_stall is low; each sample passes through
// an input register, which feeds the nearness compares and the decision, whose
// outcome is captured in the output register together with the filter state.
// A restart item clears the sample count and yields no result. The input
// stalls only when a sample waits in the input register while the output
// register is full and stalled. Configuration takes effect on the next item.
// ----------------------------------------------------------------------------
module jump_limit_filter #(
  parameter int QUOTA_MAX = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [jlf_pkg::TolW-1:0]           cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic signed [jlf_pkg::SampleW-1:0] sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [jlf_pkg::SampleW-1:0] filtered,
  output logic                               jump_held
);
  import jlf_pkg::*;

  localparam int QW = $clog2(QUOTA_MAX + 1);
  localparam int CW = ((QW > QuotaW) ? QW : QuotaW) + 1;

  logic [TolW-1:0]   tolerance;
  logic [QuotaW-1:0] quota;
  cfg_t              cfg;

  logic                      s1_valid;
  logic                      s1_mode;
  logic signed [SampleW-1:0] s1_sample;

  logic out_free;
  logic s1_go;
  logic accept;
  ctl_t ctl;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      quota     <= QUOTA_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TOLERANCE: tolerance <= cfg_data;
        REG_QUOTA:     quota     <= cfg_data[QuotaW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.tolerance = tolerance;
    if (quota == '0) begin
      cfg.quota = QuotaW'(1);
    end else if (CW'(quota) > CW'(QUOTA_MAX)) begin
      cfg.quota = QuotaW'(QUOTA_MAX);
    end else begin
      cfg.quota = quota;
    end
  end

  assign out_free       = !out_valid || !out_stall;
  assign s1_go          = s1_valid && (s1_mode || out_free);
  assign in_stall       = s1_valid && !s1_go;
  assign accept         = in_valid && !in_stall;
  assign ctl.sample_go  = s1_go && !s1_mode;
  assign ctl.restart_go = s1_go && s1_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode   <= mode;
      s1_sample <= sample;
    end
  end

  jlf_core #(
    .QUOTA_MAX (QUOTA_MAX)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .ctl    (ctl),
    .sample (s1_sample),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.sample_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sample_go) begin
      filtered  <= res.filtered;
      jump_held <= res.held;
    end
  end

  // item flow
  `JLF_ASSERT_IMP(a_stall_cause, clk, rst, in_stall, s1_valid && !s1_mode, "stall without waiting sample")
  `JLF_ASSERT_NXT(a_sample_out, clk, rst, ctl.sample_go, out_valid, "sample item gave no result")
  `JLF_ASSERT_NXT(a_restart_quiet, clk, rst, s1_valid && s1_mode && !out_valid, !out_valid, "restart gave a result")
  `JLF_ASSERT_NXT(a_out_drain, clk, rst, out_valid && !out_stall && !ctl.sample_go, !out_valid, "result repeated")

endmodule
